### hdl/tlg_pkg.sv
// ============================================================================
// tlg_pkg - shared types and constants of the toroidal life block
// Word layouts of both channels, opcodes, controller states and the control
// group that the controller hands to every row cell.
// ============================================================================
package tlg_pkg;

    // Field widths fixed by the channel words
    localparam int OPCODE_W    = 2;
    localparam int ROW_SEL_W   = 5;
    localparam int ROW_VAL_W   = 20;
    localparam int TICK_W      = 8;

    // Default grid size
    localparam int GRID_WIDTH_DEF  = 20;
    localparam int GRID_HEIGHT_DEF = 20;

    // Interval after reset
    localparam logic [TICK_W-1:0] TICKS_RESET = 8'd5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2,
        OP_STEP  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_TAIL
    } t_state;

    typedef struct packed {
        t_opcode                opcode;
        logic [ROW_SEL_W-1:0]   row_select;
        logic [ROW_VAL_W-1:0]   row_value;
    } t_in_word;

    typedef struct packed {
        logic [ROW_SEL_W-1:0]   row_index;
        logic [ROW_VAL_W-1:0]   live_cells;
        logic [ROW_VAL_W-1:0]   born_cells;
        logic [ROW_VAL_W-1:0]   died_cells;
        logic                   last_row;
    } t_out_word;

    // Control broadcast to every row cell
    typedef struct packed {
        logic                   clear;
        logic                   write;
        logic [ROW_SEL_W-1:0]   row_select;
    } t_cell_ctrl;

endpackage

### hdl/tlg_cell.sv
// ============================================================================
// tlg_cell - one row of the grid
// Holds one row of cells; loads it on a row write or clear, and hands it to
// its neighbor on the ring while a generation rotates the grid.
// ============================================================================
module tlg_cell #(
    parameter int GRID_WIDTH = tlg_pkg::GRID_WIDTH_DEF,
    parameter int ROW_INDEX  = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tlg_pkg::t_cell_ctrl     i_ctrl,
    input  logic                    i_shift,
    input  logic [GRID_WIDTH-1:0]   i_shift_in,
    input  logic [GRID_WIDTH-1:0]   i_wr_row,
    output logic [GRID_WIDTH-1:0]   o_row
);

    localparam logic [tlg_pkg::ROW_SEL_W-1:0] SelCode = tlg_pkg::ROW_SEL_W'(ROW_INDEX);
    localparam bit Reach = (ROW_INDEX < (1 << tlg_pkg::ROW_SEL_W));

    logic [GRID_WIDTH-1:0] r_row;
    logic                  w_hit;

    // Match the write address against this row
    assign w_hit = Reach && (i_ctrl.row_select == SelCode);

    // Clear, write, or take the neighbor's row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_ctrl.clear) begin
            r_row <= '0;
        end else if (i_ctrl.write && w_hit) begin
            r_row <= i_wr_row;
        end else if (i_shift) begin
            r_row <= i_shift_in;
        end
    end

    assign o_row = r_row;

endmodule

### hdl/tlg_rule.sv
// ============================================================================
// tlg_rule - B3/S23 rule for one row
// Counts the eight neighbors of every column from a three-row window, with
// the columns wrapping round, and gives the row of the next generation.
// ============================================================================
module tlg_rule #(
    parameter int GRID_WIDTH = tlg_pkg::GRID_WIDTH_DEF
) (
    input  logic [GRID_WIDTH-1:0]   i_prev,
    input  logic [GRID_WIDTH-1:0]   i_cur,
    input  logic [GRID_WIDTH-1:0]   i_next,
    output logic [GRID_WIDTH-1:0]   o_live
);

    for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_col
        localparam int XL = (x + GRID_WIDTH - 1) % GRID_WIDTH;
        localparam int XR = (x + 1) % GRID_WIDTH;

        logic [3:0] w_cnt;

        // Sum the neighbors of this column
        assign w_cnt = 4'(i_prev[XL]) + 4'(i_prev[x]) + 4'(i_prev[XR])
                     + 4'(i_cur[XL])                  + 4'(i_cur[XR])
                     + 4'(i_next[XL]) + 4'(i_next[x]) + 4'(i_next[XR]);

        // Born on three, survive on two or three
        assign o_live[x] = (w_cnt == 4'd3) || (i_cur[x] && (w_cnt == 4'd2));
    end

endmodule

### hdl/toroidal_life_generation_top.sv
// ============================================================================
// toroidal_life_generation_top - Conway life on a wrapping grid
// A ring of row cells holds the grid; a generation rotates the ring once
// through a single row rule unit and emits one word per row.
// ============================================================================
//
//  channel   direction  handshake                 word
//  --------  ---------  ------------------------  ----------------------
//  in        input      i_in_valid / o_in_stall   t_in_word  (i_in_word)
//  out       output     o_out_valid / i_out_stall t_out_word (o_out_word)
//  cfg       input      i_cfg_we                  i_cfg_wdata (interval)
//
//  A generation advances the ring one row a cycle past the rule unit while
//  the out channel does not stall, then the tail state stores the final new
//  row. A stall on the out channel holds the ring; in stays stalled until the
//  generation is done. Reset clears the grid and the tick count and sets the
//  interval to 5.
// ============================================================================
module toroidal_life_generation_top #(
    parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tlg_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tlg_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_we,
    input  logic [tlg_pkg::TICK_W-1:0]      i_cfg_wdata
);

    localparam int RW = $clog2(GRID_HEIGHT);
    localparam logic [RW-1:0] LastRow = RW'(GRID_HEIGHT - 1);

    tlg_pkg::t_state                r_state, n_state;
    logic [RW-1:0]                  r_row;
    logic [tlg_pkg::TICK_W-1:0]     r_tick, n_tick;
    logic [tlg_pkg::TICK_W-1:0]     r_interval;
    logic [GRID_WIDTH-1:0]          r_new;
    logic [GRID_WIDTH-1:0]          r_first;
    logic                           r_out_valid;
    tlg_pkg::t_out_word             r_out_word;

    logic                           w_in_acc;
    logic                           w_adv;
    logic                           w_step;
    logic                           w_tail;
    logic [tlg_pkg::TICK_W:0]       w_cnt;
    tlg_pkg::t_cell_ctrl            w_ctrl;
    logic [GRID_HEIGHT-1:0]         w_shift;
    logic [GRID_WIDTH-1:0]          w_row      [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0]          w_shift_in [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0]          w_wr_row;
    logic [GRID_WIDTH-1:0]          w_next_win;
    logic [GRID_WIDTH-1:0]          w_live;

    // Handshakes
    assign o_in_stall = (r_state != tlg_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_cnt      = {1'b0, r_tick} + 9'd1;
    assign w_wr_row   = GRID_WIDTH'(i_in_word.row_value);

    // Decode words and sequence the generation
    always_comb begin
        n_state           = r_state;
        n_tick            = r_tick;
        w_step            = 1'b0;
        w_tail            = 1'b0;
        w_ctrl.clear      = 1'b0;
        w_ctrl.write      = 1'b0;
        w_ctrl.row_select = i_in_word.row_select;
        unique case (r_state)
            tlg_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_word.opcode)
                        tlg_pkg::OP_WRITE: begin
                            w_ctrl.write = 1'b1;
                        end
                        tlg_pkg::OP_CLEAR: begin
                            w_ctrl.clear = 1'b1;
                        end
                        tlg_pkg::OP_TICK: begin
                            if (w_cnt >= {1'b0, r_interval}) begin
                                n_tick  = '0;
                                n_state = tlg_pkg::S_STEP;
                            end else begin
                                n_tick = w_cnt[tlg_pkg::TICK_W-1:0];
                            end
                        end
                        tlg_pkg::OP_STEP: begin
                            n_state = tlg_pkg::S_STEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tlg_pkg::S_STEP: begin
                if (w_adv) begin
                    w_step = 1'b1;
                    if (r_row == LastRow) begin
                        n_state = tlg_pkg::S_TAIL;
                    end
                end
            end
            tlg_pkg::S_TAIL: begin
                w_tail  = 1'b1;
                n_state = tlg_pkg::S_IDLE;
            end
            default: begin
                n_state = tlg_pkg::S_IDLE;
            end
        endcase
    end

    // Rotate all rows on a step; store only the last row on the tail cycle
    always_comb begin
        w_shift                = {GRID_HEIGHT{w_step}};
        w_shift[GRID_HEIGHT-1] = w_step || w_tail;
    end

    // Wire the ring; the new rows re-enter behind the window
    for (genvar i = 0; i < GRID_HEIGHT - 2; i++) begin : g_link
        assign w_shift_in[i] = w_row[i+1];
    end
    assign w_shift_in[GRID_HEIGHT-2] = (r_row == '0) ? w_row[GRID_HEIGHT-1] : r_new;
    assign w_shift_in[GRID_HEIGHT-1] = w_tail ? r_new : w_row[0];

    for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_cell
        tlg_cell #(
            .GRID_WIDTH (GRID_WIDTH),
            .ROW_INDEX  (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_shift    (w_shift[i]),
            .i_shift_in (w_shift_in[i]),
            .i_wr_row   (w_wr_row),
            .o_row      (w_row[i])
        );
    end

    // Use the saved first row as the lower neighbor of the last row
    assign w_next_win = (r_row == LastRow) ? r_first : w_row[1];

    tlg_rule #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_rule (
        .i_prev (w_row[GRID_HEIGHT-1]),
        .i_cur  (w_row[0]),
        .i_next (w_next_win),
        .o_live (w_live)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlg_pkg::S_IDLE;
            r_row       <= '0;
            r_tick      <= '0;
            r_interval  <= tlg_pkg::TICKS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (w_step) begin
                r_row <= (r_row == LastRow) ? '0 : r_row + RW'(1);
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the pending new row, the first old row and the output word
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_new                 <= w_live;
            r_out_word.row_index  <= tlg_pkg::ROW_SEL_W'(r_row);
            r_out_word.live_cells <= tlg_pkg::ROW_VAL_W'(w_live);
            r_out_word.born_cells <= tlg_pkg::ROW_VAL_W'(w_live & ~w_row[0]);
            r_out_word.died_cells <= tlg_pkg::ROW_VAL_W'(w_row[0] & ~w_live);
            r_out_word.last_row   <= (r_row == LastRow);
            if (r_row == '0) begin
                r_first <= w_row[0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A new output word appears only out of a generation step
    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == tlg_pkg::S_STEP)
        else $error("output word raised outside a generation");

    // A forced step always starts a generation
    a_force_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_word.opcode == tlg_pkg::OP_STEP) |=> r_state == tlg_pkg::S_STEP)
        else $error("forced step did not start a generation");

    // The tail state is followed by idle, with the ring realigned at row zero
    a_tail_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tlg_pkg::S_TAIL |=> (r_state == tlg_pkg::S_IDLE && r_row == '0))
        else $error("tail cycle did not return to idle aligned");

endmodule
